// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg - shared types and constants for the double-ended queue
// Ring buffer sizing, command codes, controller states and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DEPTH   = 1024;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int CMD_W   = 3;
	localparam int COUNT_W = 11;

	localparam logic [DATA_W-1:0] NONE_VALUE = {DATA_W{1'b1}};

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_QUERY      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;      // latch the incoming beat
		logic exec;      // apply command, write slot, read popped slot
		logic read_ends; // read front and back, capture popped data
	} dp_cmd_t;

	function automatic idx_t idx_next(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t idx_prev(input idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
	endfunction

endpackage

`default_nettype wire

// File: design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl - command sequencer
// Steps each accepted beat through execute, read and result cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	output logic                  done,
	output deq_pkg::dp_cmd_t      dp_cmd
);
	import deq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		busy              = 1'b1;
		done              = 1'b0;
		accept            = 1'b0;
		dp_cmd            = '0;
		state_d           = state_q;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			ST_EXEC: begin
				dp_cmd.exec = 1'b1;
				state_d     = ST_READ;
			end
			ST_READ: begin
				dp_cmd.read_ends = 1'b1;
				state_d          = ST_DONE;
			end
			ST_DONE: begin
				// result register is stable here, so take the next beat now
				busy    = 1'b0;
				done    = 1'b1;
				accept  = start;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (accept) begin
			dp_cmd.load = 1'b1;
			state_d     = ST_EXEC;
		end
	end

endmodule

`default_nettype wire

// File: design/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp - queue datapath
// End pointers, occupancy, slot memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire deq_pkg::dp_cmd_t              dp_cmd,
	input  wire logic [deq_pkg::CMD_W-1:0]     command,
	input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
	output logic signed [deq_pkg::DATA_W-1:0]  popped_value,
	output logic                               popped_valid,
	output logic [deq_pkg::COUNT_W-1:0]        entry_count,
	output logic                               is_empty,
	output logic signed [deq_pkg::DATA_W-1:0]  front_value,
	output logic signed [deq_pkg::DATA_W-1:0]  back_value,
	output logic                               overflow
);
	import deq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	idx_t              head_q;
	idx_t              tail_q;
	cnt_t              occ_q;
	logic              pvalid_q;
	logic              ovf_q;
	logic [DATA_W-1:0] popped_q;
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;

	logic              full;
	logic              empty;
	logic              wr_en;
	idx_t              wr_addr;
	idx_t              rd_addr_a;
	idx_t              rd_addr_b;
	idx_t              head_d;
	idx_t              tail_d;
	cnt_t              occ_d;
	logic              pvalid_d;
	logic              ovf_d;

	assign full  = (occ_q == CNT_W'(DEPTH));
	assign empty = (occ_q == '0);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = tail_q;
		head_d    = head_q;
		tail_d    = tail_q;
		occ_d     = occ_q;
		pvalid_d  = 1'b0;
		ovf_d     = 1'b0;
		rd_addr_a = head_q;
		rd_addr_b = idx_prev(tail_q);
		case (cmd_t'(cmd_q))
			CMD_PUSH_FRONT: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					head_d  = idx_prev(head_q);
					wr_addr = idx_prev(head_q);
					wr_en   = 1'b1;
					occ_d   = cnt_t'(occ_q + 1'b1);
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					tail_d  = idx_next(tail_q);
					wr_addr = tail_q;
					wr_en   = 1'b1;
					occ_d   = cnt_t'(occ_q + 1'b1);
				end
			end
			CMD_POP_FRONT: begin
				if (!empty) begin
					rd_addr_a = head_q;
					head_d    = idx_next(head_q);
					pvalid_d  = 1'b1;
					occ_d     = cnt_t'(occ_q - 1'b1);
				end
			end
			CMD_POP_BACK: begin
				if (!empty) begin
					rd_addr_a = idx_prev(tail_q);
					tail_d    = idx_prev(tail_q);
					pvalid_d  = 1'b1;
					occ_d     = cnt_t'(occ_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
		// outside the execute cycle, hold the state and read the ends
		if (!dp_cmd.exec) begin
			wr_en     = 1'b0;
			head_d    = head_q;
			tail_d    = tail_q;
			occ_d     = occ_q;
			pvalid_d  = pvalid_q;
			ovf_d     = ovf_q;
			rd_addr_a = head_q;
			rd_addr_b = idx_prev(tail_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			pvalid_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			occ_q    <= occ_d;
			pvalid_q <= pvalid_d;
			ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q <= command;
			val_q <= push_value;
		end
		if (dp_cmd.read_ends) begin
			popped_q <= rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= val_q;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	assign popped_value = pvalid_q ? popped_q : NONE_VALUE;
	assign popped_valid = pvalid_q;
	assign entry_count  = COUNT_W'(occ_q);
	assign is_empty     = empty;
	assign front_value  = empty ? NONE_VALUE : rd_a_q;
	assign back_value   = empty ? NONE_VALUE : rd_b_q;
	assign overflow     = ovf_q;

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue - ring-buffer deque with push/pop at either end
// Controller sequences each command beat; datapath holds the slots,
// end pointers and occupancy and reports the queue after each command.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Signals
//  --------  -------------------  -----------------------------------------
//  command   start & !busy        command, push_value
//  result    done (one cycle)     popped_value, popped_valid, entry_count,
//                                 is_empty, front_value, back_value, overflow
//
//  A command steps from its accepting edge to the edge that takes its result
//  through execute (pointer update, slot write, popped-slot read), read (front
//  and back slots read over the two memory read ports) and result states.
//  Busy drops in the result cycle, so the next command can be taken then.
//  Reset clears the pointers, the occupancy and the sequencer; slots are
//  not cleared, as an empty slot is never read into a result.
//  The receiver cannot stall: done is a one-cycle strobe.
//
`default_nettype none

module double_ended_queue (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [deq_pkg::CMD_W-1:0]         command,
	input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
	output logic                                   done,
	output logic signed [deq_pkg::DATA_W-1:0]      popped_value,
	output logic                                   popped_valid,
	output logic [deq_pkg::COUNT_W-1:0]            entry_count,
	output logic                                   is_empty,
	output logic signed [deq_pkg::DATA_W-1:0]      front_value,
	output logic signed [deq_pkg::DATA_W-1:0]      back_value,
	output logic                                   overflow
);
	import deq_pkg::*;

	// command bundle from sequencer to datapath
	dp_cmd_t dp_cmd;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.dp_cmd (dp_cmd)
	);

	deq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.command      (command),
		.push_value   (push_value),
		.popped_value (popped_value),
		.popped_valid (popped_valid),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.front_value  (front_value),
		.back_value   (back_value),
		.overflow     (overflow)
	);

endmodule

`default_nettype wire
